// File: design/pst_pkg.sv
package pst_pkg;

	localparam int SCALE_LOG2     = 6;
	localparam int POSITION_SCALE = 1 << SCALE_LOG2;

	localparam int VALUE_W  = 32;
	localparam int REF_W    = 48;
	localparam int DELTA_W  = REF_W + 1;
	localparam int IDX_W    = 24;
	localparam int ERR_W    = VALUE_W + 1;
	localparam int EDIFF_W  = ERR_W + 1;
	localparam int SUM_W    = 52;
	localparam int BRAKE_W  = 64;
	localparam int CMP_W    = IDX_W + 18;

	localparam int DRIVE_MAG_W = 8;
	localparam int DRIVE_W     = DRIVE_MAG_W + 1;
	localparam int GAIN_W      = 16;
	localparam int SPEED_W     = 24;
	localparam int ACCEL_W     = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_TDATA_W = 48;

	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int TRI_W    = 2 * IDX_W;
	localparam int HALF_W   = TRI_W - 1;
	localparam int LO_SPLIT = 24;
	localparam int LOP_W    = LO_SPLIT + ACCEL_W;
	localparam int HIP_W    = HALF_W - LO_SPLIT + ACCEL_W;

	localparam int DRIVE_DIV  = 100;
	localparam int THRESH_W   = 16;
	localparam int DIV_IN_W   = 15;
	localparam int DIV_MUL    = 5243;
	localparam int DIV_SHIFT  = 19;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DRIVE    = 3'd0,
		REG_GAIN_P       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_SPEED_LIMIT  = 3'd3,
		REG_ACCEL_STEP   = 3'd4,
		REG_TRAPEZOID_ON = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DRIVE_MAG_W-1:0] max_drive;
		logic [GAIN_W-1:0]      gain_p;
		logic [GAIN_W-1:0]      gain_d;
		logic [SPEED_W-1:0]     speed_limit;
		logic [ACCEL_W-1:0]     accel_step;
		logic                   trapezoid_on;
	} cfg_t;

	typedef struct packed {
		logic                      tick;
		logic                      load;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [VALUE_W-1:0] reference_position;
	} res_t;

endpackage

// File: design/pd_position_servo_trapezoid_unit.sv
// Position servo for one motor axis, PD drive law with optional trapezoid profile.
// s_* channel: one item per command; tuser[0] = 1 loads a new target (taken while
// idle, no result), tuser[0] = 0 is a control tick carrying the measured
// position in tdata and produces exactly one result item on m_*.
// cfg_* channel: register writes (index, data), always ready; write only while idle.
// A tick walks a small sequencer around one shared 35x25 multiplier in plain slew
// mode or trapezoid mode (in trapezoid mode the braking distance takes three
// products, the speed cap and the reference step one each, the PD law two, the
// divide by 100 one). s_tready is low from accept until the result is loaded.
// The result appears on m_tvalid the cycle after the sequencer finishes; the next
// item is taken in that same cycle.
// If m_tready holds off, the finished result waits in the output register and a
// following tick stops at its last step until that register frees up.
// Reset clears the configuration, target, reference, speed index and previous error
// to zero and drops m_tvalid; working registers and output data are not reset.
module pd_position_servo_trapezoid_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [pst_pkg::VALUE_W-1:0]           s_tdata,   // value
	input  logic [0:0]                            s_tuser,   // action
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [pst_pkg::OUT_TDATA_W-1:0]       m_tdata,   // drive, reference_position
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pst_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]        cfg_data
);

	pst_pkg::cfg_t  cfg;
	pst_pkg::cmd_t  cmd;
	pst_pkg::stat_t stat;
	pst_pkg::res_t  res;
	pst_pkg::res_t  out_q;
	logic           out_valid_q;
	logic           out_free;
	logic           s_acc;

	assign cfg_ready = 1'b1;
	assign s_tready  = !stat.busy;
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign cmd.tick  = s_acc && (s_tuser[0] == pst_pkg::ACT_TICK);
	assign cmd.load  = s_acc && (s_tuser[0] == pst_pkg::ACT_LOAD);
	assign cmd.value = signed'(s_tdata);

	pst_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg_q    (cfg)
	);

	pst_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.out_free (out_free),
		.stat     (stat),
		.res      (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(pst_pkg::OUT_TDATA_W - pst_pkg::DRIVE_W - pst_pkg::VALUE_W){1'b0}},
		out_q.reference_position, out_q.drive};

endmodule

// File: design/pst_cfg.sv
module pst_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [pst_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]   wr_data,
	output pst_pkg::cfg_t                    cfg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				pst_pkg::REG_MAX_DRIVE: begin
					cfg_q.max_drive <= wr_data[pst_pkg::DRIVE_MAG_W-1:0];
				end
				pst_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= wr_data[pst_pkg::GAIN_W-1:0];
				end
				pst_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= wr_data[pst_pkg::GAIN_W-1:0];
				end
				pst_pkg::REG_SPEED_LIMIT: begin
					cfg_q.speed_limit <= wr_data[pst_pkg::SPEED_W-1:0];
				end
				pst_pkg::REG_ACCEL_STEP: begin
					cfg_q.accel_step <= wr_data[pst_pkg::ACCEL_W-1:0];
				end
				pst_pkg::REG_TRAPEZOID_ON: begin
					cfg_q.trapezoid_on <= wr_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/pst_mul.sv
module pst_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [pst_pkg::MUL_A_W-1:0]  a,
	input  logic signed [pst_pkg::MUL_B_W-1:0]  b,
	output logic signed [pst_pkg::MUL_P_W-1:0]  p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= pst_pkg::MUL_P_W'(a) * pst_pkg::MUL_P_W'(b);
		end
	end

endmodule

// File: design/pst_core.sv
module pst_core (
	input  logic            clk,
	input  logic            arst_n,
	input  pst_pkg::cfg_t   cfg,
	input  pst_pkg::cmd_t   cmd,
	input  logic            out_free,
	output pst_pkg::stat_t  stat,
	output pst_pkg::res_t   res
);

	typedef enum logic [18:0] {
		ST_IDLE     = 19'h00001,
		ST_DELTA    = 19'h00002,
		ST_BRK_LO   = 19'h00004,
		ST_BRK_HI   = 19'h00008,
		ST_BRK_SUM  = 19'h00010,
		ST_STEP     = 19'h00020,
		ST_CAP_MUL  = 19'h00040,
		ST_CAP      = 19'h00080,
		ST_MOVE_MUL = 19'h00100,
		ST_MOVE     = 19'h00200,
		ST_PLAIN    = 19'h00400,
		ST_POS      = 19'h00800,
		ST_ERR      = 19'h01000,
		ST_MUL_P    = 19'h02000,
		ST_MUL_D    = 19'h04000,
		ST_SUM      = 19'h08000,
		ST_ABS      = 19'h10000,
		ST_DIV      = 19'h20000,
		ST_FIN      = 19'h40000
	} state_t;

	localparam logic signed [pst_pkg::IDX_W-1:0] IDX_ZERO = '0;
	localparam logic signed [pst_pkg::IDX_W-1:0] IDX_ONE  = pst_pkg::IDX_W'(1);
	localparam logic signed [pst_pkg::IDX_W-1:0] IDX_TWO  = pst_pkg::IDX_W'(2);
	localparam logic signed [pst_pkg::IDX_W-1:0] IDX_MAX  =
		pst_pkg::IDX_W'(2 ** (pst_pkg::IDX_W - 1) - 1);
	localparam logic signed [pst_pkg::IDX_W-1:0] IDX_MIN  =
		{1'b1, {(pst_pkg::IDX_W-1){1'b0}}};

	state_t state_q;

	logic signed [pst_pkg::REF_W-1:0]   ref_q;
	logic signed [pst_pkg::REF_W-1:0]   target_q;
	logic signed [pst_pkg::IDX_W-1:0]   idx_q;
	logic signed [pst_pkg::ERR_W-1:0]   prev_q;

	logic signed [pst_pkg::VALUE_W-1:0] value_q;
	logic signed [pst_pkg::DELTA_W-1:0] delta_q;
	logic        [pst_pkg::DELTA_W-1:0] adelta_q;
	logic        [pst_pkg::HALF_W-1:0]  half_q;
	logic        [pst_pkg::LOP_W-1:0]   lo_q;
	logic        [pst_pkg::BRAKE_W-1:0] brake_q;
	logic signed [pst_pkg::IDX_W-1:0]   n1_q;
	logic signed [pst_pkg::VALUE_W-1:0] refpos_q;
	logic signed [pst_pkg::ERR_W-1:0]   err_q;
	logic signed [pst_pkg::EDIFF_W-1:0] ediff_q;
	logic signed [pst_pkg::SUM_W-1:0]   sum_q;
	logic        [pst_pkg::SUM_W-1:0]   mag_q;
	logic                               neg_q;
	logic                               sat_q;

	logic                               mul_en;
	logic signed [pst_pkg::MUL_A_W-1:0] mul_a;
	logic signed [pst_pkg::MUL_B_W-1:0] mul_b;
	logic signed [pst_pkg::MUL_P_W-1:0] mul_p;

	logic        [pst_pkg::IDX_W-1:0]   an;
	logic signed [pst_pkg::DELTA_W-1:0] dlt;
	logic signed [pst_pkg::DELTA_W-1:0] ndlt;
	logic                               go;
	logic signed [pst_pkg::IDX_W-1:0]   n_up;
	logic signed [pst_pkg::IDX_W-1:0]   n_dn;
	logic signed [pst_pkg::IDX_W-1:0]   n1;
	logic signed [pst_pkg::CMP_W-1:0]   p_cap;
	logic signed [pst_pkg::CMP_W-1:0]   vm;
	logic signed [pst_pkg::CMP_W-1:0]   ac;
	logic signed [pst_pkg::IDX_W-1:0]   n_cap;
	logic signed [pst_pkg::DELTA_W-1:0] vmax_d;
	logic signed [pst_pkg::REF_W-1:0]   vmax_r;
	logic signed [pst_pkg::REF_W-1:0]   ref_plain;
	logic signed [pst_pkg::REF_W-1:0]   rbias;
	logic        [pst_pkg::THRESH_W-1:0] thresh;
	logic signed [pst_pkg::DRIVE_W-1:0] q_fin;
	logic signed [pst_pkg::DRIVE_W-1:0] drive_fin;

	pst_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// profile arithmetic
	always_comb begin
		an   = idx_q[pst_pkg::IDX_W-1] ? unsigned'(-idx_q) : unsigned'(idx_q);
		dlt  = pst_pkg::DELTA_W'(target_q) - pst_pkg::DELTA_W'(ref_q);
		ndlt = pst_pkg::DELTA_W'(ref_q) - pst_pkg::DELTA_W'(target_q);
		go   = pst_pkg::BRAKE_W'(adelta_q) >= brake_q;
		n_up = (idx_q < IDX_MAX) ? idx_q + IDX_ONE : idx_q;
		n_dn = (idx_q > -IDX_MAX) ? idx_q - IDX_ONE : idx_q;
		if (go) begin
			n1 = delta_q[pst_pkg::DELTA_W-1] ? n_dn : n_up;
		end else if (idx_q > IDX_ZERO) begin
			n1 = idx_q - IDX_ONE;
		end else if (idx_q < IDX_ZERO) begin
			n1 = idx_q + IDX_ONE;
		end else begin
			n1 = idx_q;
		end

		p_cap = pst_pkg::CMP_W'(mul_p);
		vm    = signed'(pst_pkg::CMP_W'(cfg.speed_limit));
		ac    = signed'(pst_pkg::CMP_W'(cfg.accel_step));
		n_cap = n1_q;
		if (!delta_q[pst_pkg::DELTA_W-1]) begin
			if (p_cap > vm) begin
				n_cap = n1_q - IDX_ONE;
				if (p_cap - ac > vm) begin
					n_cap = n1_q - IDX_TWO;
				end
			end
		end else begin
			if (p_cap < -vm) begin
				n_cap = n1_q + IDX_ONE;
				if (p_cap + ac < -vm) begin
					n_cap = n1_q + IDX_TWO;
				end
			end
		end

		vmax_d = signed'(pst_pkg::DELTA_W'(cfg.speed_limit));
		vmax_r = signed'(pst_pkg::REF_W'(cfg.speed_limit));
		if (delta_q > vmax_d) begin
			ref_plain = ref_q + vmax_r;
		end else if (delta_q < -vmax_d) begin
			ref_plain = ref_q - vmax_r;
		end else begin
			ref_plain = target_q;
		end

		// truncate toward zero on the way down to ticks
		rbias = ref_q + (ref_q[pst_pkg::REF_W-1] ?
			pst_pkg::REF_W'(pst_pkg::POSITION_SCALE - 1) : pst_pkg::REF_W'(0));

		thresh = pst_pkg::THRESH_W'((pst_pkg::THRESH_W'(cfg.max_drive) +
			pst_pkg::THRESH_W'(1)) * pst_pkg::DRIVE_DIV);
		q_fin = sat_q ? signed'(pst_pkg::DRIVE_W'(cfg.max_drive)) :
			signed'(mul_p[pst_pkg::DIV_SHIFT +: pst_pkg::DRIVE_W]);
		drive_fin = neg_q ? -q_fin : q_fin;
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_DELTA: begin
				mul_en = 1'b1;
				mul_a  = signed'(pst_pkg::MUL_A_W'(an) + pst_pkg::MUL_A_W'(1));
				mul_b  = signed'(pst_pkg::MUL_B_W'(an) + pst_pkg::MUL_B_W'(2));
			end
			ST_BRK_LO: begin
				mul_en = 1'b1;
				mul_a  = signed'(pst_pkg::MUL_A_W'(mul_p[pst_pkg::LO_SPLIT:1]));
				mul_b  = signed'(pst_pkg::MUL_B_W'(cfg.accel_step));
			end
			ST_BRK_HI: begin
				mul_en = 1'b1;
				mul_a  = signed'(pst_pkg::MUL_A_W'(
					half_q[pst_pkg::HALF_W-1:pst_pkg::LO_SPLIT]));
				mul_b  = signed'(pst_pkg::MUL_B_W'(cfg.accel_step));
			end
			ST_CAP_MUL: begin
				mul_en = 1'b1;
				mul_a  = pst_pkg::MUL_A_W'(n1_q);
				mul_b  = signed'(pst_pkg::MUL_B_W'(cfg.accel_step));
			end
			ST_MOVE_MUL: begin
				mul_en = 1'b1;
				mul_a  = pst_pkg::MUL_A_W'(idx_q);
				mul_b  = signed'(pst_pkg::MUL_B_W'(cfg.accel_step));
			end
			ST_MUL_P: begin
				mul_en = 1'b1;
				mul_a  = pst_pkg::MUL_A_W'(err_q);
				mul_b  = signed'(pst_pkg::MUL_B_W'(cfg.gain_p));
			end
			ST_MUL_D: begin
				mul_en = 1'b1;
				mul_a  = pst_pkg::MUL_A_W'(ediff_q);
				mul_b  = signed'(pst_pkg::MUL_B_W'(cfg.gain_d));
			end
			ST_DIV: begin
				mul_en = 1'b1;
				mul_a  = signed'(pst_pkg::MUL_A_W'(mag_q[pst_pkg::DIV_IN_W-1:0]));
				mul_b  = signed'(pst_pkg::MUL_B_W'(pst_pkg::DIV_MUL));
			end
			default: begin
			end
		endcase
	end

	// sequencer and servo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ref_q    <= '0;
			target_q <= '0;
			idx_q    <= '0;
			prev_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						target_q <= pst_pkg::REF_W'(cmd.value) <<< pst_pkg::SCALE_LOG2;
					end
					if (cmd.tick) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					state_q <= cfg.trapezoid_on ? ST_BRK_LO : ST_PLAIN;
				end
				ST_BRK_LO: begin
					state_q <= ST_BRK_HI;
				end
				ST_BRK_HI: begin
					state_q <= ST_BRK_SUM;
				end
				ST_BRK_SUM: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (go) begin
						state_q <= ST_CAP_MUL;
					end else begin
						idx_q   <= n1;
						state_q <= ST_MOVE_MUL;
					end
				end
				ST_CAP_MUL: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					idx_q   <= n_cap;
					state_q <= ST_MOVE_MUL;
				end
				ST_MOVE_MUL: begin
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					ref_q   <= ref_q + pst_pkg::REF_W'(mul_p);
					state_q <= ST_POS;
				end
				ST_PLAIN: begin
					ref_q   <= ref_plain;
					state_q <= ST_POS;
				end
				ST_POS: begin
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					prev_q  <= err_q;
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of one tick
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.tick) begin
					value_q <= cmd.value;
				end
			end
			ST_DELTA: begin
				delta_q  <= dlt;
				adelta_q <= dlt[pst_pkg::DELTA_W-1] ? unsigned'(ndlt) : unsigned'(dlt);
			end
			ST_BRK_LO: begin
				half_q <= mul_p[pst_pkg::TRI_W-1:1];
			end
			ST_BRK_HI: begin
				lo_q <= mul_p[pst_pkg::LOP_W-1:0];
			end
			ST_BRK_SUM: begin
				brake_q <= (pst_pkg::BRAKE_W'(mul_p[pst_pkg::HIP_W-1:0]) << pst_pkg::LO_SPLIT)
					+ pst_pkg::BRAKE_W'(lo_q);
			end
			ST_STEP: begin
				n1_q <= n1;
			end
			ST_POS: begin
				refpos_q <= rbias[pst_pkg::SCALE_LOG2 +: pst_pkg::VALUE_W];
			end
			ST_ERR: begin
				err_q <= pst_pkg::ERR_W'(refpos_q) - pst_pkg::ERR_W'(value_q);
			end
			ST_MUL_P: begin
				ediff_q <= pst_pkg::EDIFF_W'(err_q) - pst_pkg::EDIFF_W'(prev_q);
			end
			ST_MUL_D: begin
				sum_q <= pst_pkg::SUM_W'(mul_p);
			end
			ST_SUM: begin
				sum_q <= sum_q + pst_pkg::SUM_W'(mul_p);
			end
			ST_ABS: begin
				neg_q <= sum_q[pst_pkg::SUM_W-1];
				mag_q <= sum_q[pst_pkg::SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
			end
			ST_DIV: begin
				sat_q <= mag_q >= pst_pkg::SUM_W'(thresh);
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_FIN) && out_free;
	assign res.drive = drive_fin;
	assign res.reference_position = refpos_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != IDX_MIN)
		else $error("speed index reached its negative limit");

	a_plain_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLAIN) |=> $stable(idx_q))
		else $error("speed index moved in plain slew mode");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !sat_q) |->
		(mul_p[pst_pkg::DIV_SHIFT +: pst_pkg::DRIVE_W] <= {1'b0, cfg.max_drive}))
		else $error("unsaturated quotient exceeds drive limit");

endmodule
